[src/bhp_pkg.sv]
// Shared types, constants and request codes of the bucket histogram percentile unit.
// Used by the channel interfaces and by every module of the block.
package bhp_pkg;

  localparam int NUM_BOUNDARIES_DEF = 7;
  localparam int SAMPLE_WIDTH_DEF   = 32;

  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = 3;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 32;
  localparam int REQ_W      = 2;
  localparam int IDX_W      = 3;
  localparam int CUM_W      = CNT_W + IDX_W;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_OBSERVE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  localparam int MUL_P90   = 9;
  localparam int DIV_P90   = 10;
  localparam int MUL_P99   = 99;
  localparam int DIV_P99   = 100;
  localparam int PROD_W    = CNT_W + 7;
  localparam int SCL_W     = CUM_W + $clog2(DIV_P99);

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] bnd_array_t;

  localparam bnd_array_t BND_RESET = {
    32'd100000, 32'd50000, 32'd10000, 32'd5000, 32'd1000, 32'd500, 32'd100
  };

  typedef struct packed {
    logic             obs_take;
    logic             clr;
    logic             prep;
    logic             walk_step;
    logic [IDX_W-1:0] walk_idx;
    logic             load_out;
  } bhp_cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0]  total_sum;
    logic [CNT_W-1:0]  total_count;
    logic [DATA_W-1:0] min_seen;
    logic [DATA_W-1:0] max_seen;
    logic [DATA_W-1:0] p50_estimate;
    logic [DATA_W-1:0] p90_estimate;
    logic [DATA_W-1:0] p99_estimate;
  } bhp_res_t;

endpackage

[src/bhp_req_if.sv]
// Request channel: valid/ready handshake carrying the request code and the sample.
// Depends on bhp_pkg.
interface bhp_req_if;
  import bhp_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] sample_value;

  modport source (output valid, output req_type, output sample_value, input ready);
  modport sink (input valid, input req_type, input sample_value, output ready);
endinterface

[src/bhp_rsp_if.sv]
// Result channel: valid/ready handshake carrying one statistics report.
// Depends on bhp_pkg.
interface bhp_rsp_if;
  import bhp_pkg::*;

  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  total_sum;
  logic [CNT_W-1:0]  total_count;
  logic [DATA_W-1:0] min_seen;
  logic [DATA_W-1:0] max_seen;
  logic [DATA_W-1:0] p50_estimate;
  logic [DATA_W-1:0] p90_estimate;
  logic [DATA_W-1:0] p99_estimate;

  modport source (
    output valid, output total_sum, output total_count, output min_seen, output max_seen,
    output p50_estimate, output p90_estimate, output p99_estimate, input ready
  );
  modport sink (
    input valid, input total_sum, input total_count, input min_seen, input max_seen,
    input p50_estimate, input p90_estimate, input p99_estimate, output ready
  );
endinterface

[src/bucket_histogram_percentile_unit.sv]
// Bucketed histogram with percentile estimates over unsigned samples.
// Requests arrive on the req channel (observe, report, clear); each report produces one
// transfer on the rsp channel carrying sum, count, min, max and p50/p90/p99 estimates.
// The seven bucket boundaries are APB registers at byte addresses 0, 4, ... 24 and must
// be written in ascending order while the unit is idle.
// An observe or clear request is taken every cycle while no report holds off the channel;
// a clear takes effect at its transfer, an observe updates the statistics in the cycle
// after its transfer, and either is visible to any following request.
// A report holds off the request channel through a setup step for the percentile
// targets, one walk step per bucket over the cumulative counts, and a result load,
// which waits while an earlier result is still untaken.
// The result is valid in the cycle after that load and stays until the receiver takes
// it; while it waits, observe and clear requests are still taken, and a further report
// waits at its final load step.
// Reset restores the default boundaries, empties all buckets and statistics and drops
// any pending result.
// Depends on bhp_pkg, bhp_req_if, bhp_rsp_if, bhp_regs, bhp_ctrl and bhp_dp.
module bucket_histogram_percentile_unit #(
  parameter int NUM_BOUNDARIES = bhp_pkg::NUM_BOUNDARIES_DEF,
  parameter int SAMPLE_WIDTH   = bhp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bhp_req_if.sink                        req,
  bhp_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bhp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bhp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bhp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bhp_pkg::*;

  bnd_array_t bnd;
  bhp_cmd_t   cmd;
  bhp_res_t   res;
  logic       req_ready;
  logic       out_valid;

  bhp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bnd     (bnd)
  );

  bhp_ctrl #(
    .NUM_BOUNDARIES (NUM_BOUNDARIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  bhp_dp #(
    .NUM_BOUNDARIES (NUM_BOUNDARIES),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .bnd          (bnd),
    .sample_value (req.sample_value),
    .res          (res)
  );

  assign req.ready        = req_ready;
  assign rsp.valid        = out_valid;
  assign rsp.total_sum    = res.total_sum;
  assign rsp.total_count  = res.total_count;
  assign rsp.min_seen     = res.min_seen;
  assign rsp.max_seen     = res.max_seen;
  assign rsp.p50_estimate = res.p50_estimate;
  assign rsp.p90_estimate = res.p90_estimate;
  assign rsp.p99_estimate = res.p99_estimate;

endmodule

[src/bhp_regs.sv]
// APB register file holding the seven bucket boundaries.
// Depends on bhp_pkg.
module bhp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bhp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bhp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bhp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bhp_pkg::bnd_array_t              bnd
);
  import bhp_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 idx_ok;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign idx_ok = idx < REG_IDX_W'(NUM_REGS);
  assign pready = 1'b1;
  assign prdata = idx_ok ? APB_DATA_W'(bnd[idx]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd <= BND_RESET;
    end else if (psel && penable && pwrite && idx_ok) begin
      bnd[idx] <= pwdata[DATA_W-1:0];
    end
  end

endmodule

[src/bhp_ctrl.sv]
// Controller of the histogram unit: request decode, report sequencing and result valid.
// Depends on bhp_pkg; drives the datapath through bhp_cmd_t.
module bhp_ctrl #(
  parameter int NUM_BOUNDARIES = bhp_pkg::NUM_BOUNDARIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [bhp_pkg::REQ_W-1:0]   req_type,
  output logic                        req_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bhp_pkg::bhp_cmd_t           cmd
);
  import bhp_pkg::*;

  localparam int KW = $clog2(NUM_BOUNDARIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [KW-1:0]        walk_idx;
  logic                 acc;
  logic                 out_free;

  assign req_ready = (state == ST_IDLE);
  assign acc       = req_valid && req_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.obs_take  = acc && (req_type == REQ_OBSERVE);
    cmd.clr       = acc && (req_type == REQ_CLEAR);
    cmd.prep      = (state == ST_PREP);
    cmd.walk_step = (state == ST_WALK);
    cmd.walk_idx  = IDX_W'(walk_idx);
    cmd.load_out  = (state == ST_LOAD) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && (req_type == REQ_REPORT)) state_next = ST_PREP;
      end
      ST_PREP: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_idx == KW'(NUM_BOUNDARIES)) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        walk_idx <= '0;
      end else if (state == ST_WALK) begin
        walk_idx <= walk_idx + KW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register loaded while a result still waits");

  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    (acc && (req_type == REQ_REPORT)) |=> (state == ST_PREP))
    else $error("accepted report did not start the report sequence");

  a_prep_to_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |=> (state == ST_WALK && walk_idx == '0))
    else $error("walk did not start from the first bucket after setup");

endmodule

[src/bhp_dp.sv]
// Datapath of the histogram unit: bucket counters, running statistics, percentile
// targets, cumulative walk and result register. Depends on bhp_pkg.
module bhp_dp #(
  parameter int NUM_BOUNDARIES = bhp_pkg::NUM_BOUNDARIES_DEF,
  parameter int SAMPLE_WIDTH   = bhp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bhp_pkg::bhp_cmd_t             cmd,
  input  bhp_pkg::bnd_array_t           bnd,
  input  logic [bhp_pkg::DATA_W-1:0]    sample_value,
  output bhp_pkg::bhp_res_t             res
);
  import bhp_pkg::*;

  localparam int NB  = NUM_BOUNDARIES;
  localparam int NBK = NB + 1;
  localparam int KW  = $clog2(NB + 1);
  localparam int SW  = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;

  // Observe pipeline: bucket index is found at the transfer, statistics update next cycle.
  logic [SW-1:0]     in_s;
  logic [DATA_W-1:0] in_ext;
  logic [KW-1:0]     k_cnt;
  logic              obs_pend;
  logic [KW-1:0]     obs_k;
  logic [SW-1:0]     obs_v;
  logic [DATA_W-1:0] v_ext;
  logic [SUM_W:0]    sum_add;

  logic [DATA_W-1:0] bucket [NBK];
  logic [SUM_W-1:0]  run_sum;
  logic [CNT_W-1:0]  run_count;
  logic [DATA_W-1:0] run_min;
  logic [DATA_W-1:0] run_max;

  // Report: targets and walk.
  logic [CNT_W-1:0]   t50;
  logic [PROD_W-1:0]  goal90;
  logic [PROD_W-1:0]  goal99;
  logic [SCL_W-1:0]   cum_inc;
  logic               hit50;
  logic               hit90;
  logic               hit99;
  logic [CUM_W-1:0]   cum;
  logic [CUM_W-1:0]   cum_next;
  logic [2:0]         found;
  logic [DATA_W-1:0]  p50;
  logic [DATA_W-1:0]  p90;
  logic [DATA_W-1:0]  p99;
  logic [KW-1:0]      widx;
  logic [REG_IDX_W-1:0] prev_idx;
  logic [DATA_W-1:0]  step_bnd;
  logic [DATA_W-1:0]  last_bnd;

  assign in_s   = sample_value[SW-1:0];
  assign in_ext = DATA_W'(in_s);

  always_comb begin
    k_cnt = '0;
    for (int i = 0; i < NB; i++) begin
      if (bnd[i] <= in_ext) k_cnt = k_cnt + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_pend <= 1'b0;
    end else begin
      obs_pend <= cmd.obs_take;
    end
    if (cmd.obs_take) begin
      obs_k <= k_cnt;
      obs_v <= in_s;
    end
  end

  assign v_ext   = DATA_W'(obs_v);
  assign sum_add = {1'b0, run_sum} + (SUM_W + 1)'(v_ext);

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      run_sum   <= '0;
      run_count <= '0;
      run_min   <= '1;
      run_max   <= '0;
    end else if (obs_pend) begin
      run_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      if (run_count != '1) run_count <= run_count + CNT_W'(1);
      if (v_ext < run_min) run_min <= v_ext;
      if (v_ext > run_max) run_max <= v_ext;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NBK; i++) begin
      if (rst || cmd.clr) begin
        bucket[i] <= '0;
      end else if (obs_pend && obs_k == KW'(i) && bucket[i] != '1) begin
        bucket[i] <= bucket[i] + DATA_W'(1);
      end
    end
  end

  assign widx     = cmd.walk_idx[KW-1:0];
  assign prev_idx = REG_IDX_W'(widx) - REG_IDX_W'(1);
  assign last_bnd = bnd[NB-1];
  assign cum_next = cum + CUM_W'(bucket[widx]);

  // The running total reaches floor(count * n / d) exactly when (total + 1) * d > count * n.
  assign cum_inc = SCL_W'(cum_next) + SCL_W'(1);
  assign hit50   = cum_next >= CUM_W'(t50);
  assign hit90   = (cum_inc * SCL_W'(DIV_P90)) > SCL_W'(goal90);
  assign hit99   = (cum_inc * SCL_W'(DIV_P99)) > SCL_W'(goal99);

  always_comb begin
    if (widx == '0) begin
      step_bnd = bnd[0];
    end else if (widx >= KW'(NB)) begin
      step_bnd = last_bnd;
    end else begin
      step_bnd = bnd[prev_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      t50    <= run_count >> 1;
      goal90 <= PROD_W'(run_count) * PROD_W'(MUL_P90);
      goal99 <= PROD_W'(run_count) * PROD_W'(MUL_P99);
      cum    <= '0;
      found  <= '0;
      p50    <= last_bnd;
      p90    <= last_bnd;
      p99    <= last_bnd;
    end else if (cmd.walk_step) begin
      cum <= cum_next;
      if (!found[0] && hit50) begin
        found[0] <= 1'b1;
        p50      <= step_bnd;
      end
      if (!found[1] && hit90) begin
        found[1] <= 1'b1;
        p90      <= step_bnd;
      end
      if (!found[2] && hit99) begin
        found[2] <= 1'b1;
        p99      <= step_bnd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (run_count == '0) begin
        res <= '0;
      end else begin
        res.total_sum    <= run_sum;
        res.total_count  <= run_count;
        res.min_seen     <= run_min;
        res.max_seen     <= run_max;
        res.p50_estimate <= p50;
        res.p90_estimate <= p90;
        res.p99_estimate <= p99;
      end
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |=> (run_count == '0 && run_sum == '0))
    else $error("clear did not empty the running statistics");

  a_observe_counts: assert property (@(posedge clk) disable iff (rst)
    (obs_pend && !cmd.clr) |=> (run_count != '0))
    else $error("observed sample left the count at zero");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (obs_pend && !cmd.clr) |=> (run_min <= run_max))
    else $error("running minimum above running maximum after a sample");

endmodule
